FILE: src/cdq_pkg.sv
// shared constants and operation codes for the circular deque
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 3;
   localparam int DEPTH_DEFAULT = 16;

   // operation codes carried on the request side; unlisted codes act as a peek
   localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_PEEK       = 3'd4;

endpackage

FILE: src/cdq_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = cdq_pkg::WORD_W,
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

FILE: src/circular_deque_unit.sv
// circular deque top level: request register, ring store with cached ends, result register
// an accepted request is held in the request register, then its result in the result register
// throughput: one op per cycle while rsp_tready is high, pushes and pops of either end in any mix
// the ram registers the neighbor of each end as the pointers update, so the cached ends refill
// reset clears pointers, empty mark and valid bits; the ring store itself is not cleared
`timescale 1ns / 1ps

module circular_deque_unit #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // push_value[31:0]
   input  logic [7:0]    req_tuser,   // func[2:0], zero[7:3]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // popped_value[31:0], front_value[63:32], rear_value[95:64]
   output logic [7:0]    rsp_tuser    // ok[0], is_empty[1], is_full[2], zero[7:3]
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW = cdq_pkg::WORD_W;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
      return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
   endfunction

   // request register
   logic                      op_vld_ff, op_vld_in;
   logic [cdq_pkg::FUNC_W-1:0] op_func_ff;
   logic [WW-1:0]             op_value_ff;

   // deque state
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;
   logic [WW-1:0] front_ff, front_in;
   logic [WW-1:0] rear_ff, rear_in;

   // ram and forwarding
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [WW-1:0] rd_data_a, rd_data_b;
   logic          hit_a_ff, hit_b_ff;
   logic [WW-1:0] byp_ff;
   logic [WW-1:0] next_front, next_rear;

   // result register
   logic          out_vld_ff, out_vld_in;
   logic          ok_ff, ok_in;
   logic          is_empty_ff;
   logic          is_full_ff, is_full_in;
   logic [WW-1:0] popped_ff, popped_in;
   logic [WW-1:0] front_out_ff, rear_out_ff;

   logic go;
   logic full_now;
   logic single;

   assign go         = op_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !op_vld_ff || go;
   assign full_now   = !empty_ff && (nxt(tail_ff) == head_ff);
   assign single     = !empty_ff && (head_ff == tail_ff);

   // ram words beside each end, with the write of the same edge forwarded
   assign next_front = hit_a_ff ? byp_ff : rd_data_a;
   assign next_rear  = hit_b_ff ? byp_ff : rd_data_b;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      ok_in     = 1'b0;
      popped_in = '0;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      wr_data   = op_value_ff;
      if (go) begin
         unique case (op_func_ff)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  front_in = op_value_ff;
                  rear_in  = op_value_ff;
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  ok_in    = 1'b1;
               end else if (!full_now) begin
                  if (op_func_ff == cdq_pkg::OP_PUSH_FRONT) begin
                     head_in  = prv(head_ff);
                     wr_addr  = prv(head_ff);
                     front_in = op_value_ff;
                  end else begin
                     tail_in = nxt(tail_ff);
                     wr_addr = nxt(tail_ff);
                     rear_in = op_value_ff;
                  end
                  wr_en = 1'b1;
                  ok_in = 1'b1;
               end
            end
            cdq_pkg::OP_POP_FRONT: begin
               if (!empty_ff) begin
                  ok_in     = 1'b1;
                  popped_in = front_ff;
                  if (single) begin
                     empty_in = 1'b1;
                  end else begin
                     head_in  = nxt(head_ff);
                     front_in = next_front;
                  end
               end
            end
            cdq_pkg::OP_POP_REAR: begin
               if (!empty_ff) begin
                  ok_in     = 1'b1;
                  popped_in = rear_ff;
                  if (single) begin
                     empty_in = 1'b1;
                  end else begin
                     tail_in = prv(tail_ff);
                     rear_in = next_rear;
                  end
               end
            end
            default: begin
               // peek and unused codes leave the state alone
            end
         endcase
      end
      rd_addr_a  = nxt(head_in);
      rd_addr_b  = prv(tail_in);
      is_full_in = !empty_in && (nxt(tail_in) == head_in);
   end

   always_comb begin
      op_vld_in = op_vld_ff;
      if (req_tvalid && req_tready) begin
         op_vld_in = 1'b1;
      end else if (go) begin
         op_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (go) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         empty_ff   <= 1'b1;
      end else begin
         op_vld_ff  <= op_vld_in;
         out_vld_ff <= out_vld_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         empty_ff   <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_func_ff  <= req_tuser[cdq_pkg::FUNC_W-1:0];
         op_value_ff <= req_tdata[WW-1:0];
      end
      front_ff <= front_in;
      rear_ff  <= rear_in;
      hit_a_ff <= wr_en && (wr_addr == rd_addr_a);
      hit_b_ff <= wr_en && (wr_addr == rd_addr_b);
      byp_ff   <= wr_data;
      if (go) begin
         ok_ff        <= ok_in;
         popped_ff    <= popped_in;
         is_empty_ff  <= empty_in;
         is_full_ff   <= is_full_in;
         front_out_ff <= empty_in ? '0 : front_in;
         rear_out_ff  <= empty_in ? '0 : rear_in;
      end
   end

   cdq_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {rear_out_ff, front_out_ff, popped_ff};
   assign rsp_tuser  = {5'b0, is_full_ff, is_empty_ff, ok_ff};

   // pointers never leave the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= AW'(DEPTH - 1)) && (tail_ff <= AW'(DEPTH - 1)))
      else $error("deque pointer out of range");

   // a refused push leaves both pointers where they were
   a_refused_push: assert property (@(posedge clock) disable iff (reset)
      go && full_now && (op_func_ff == cdq_pkg::OP_PUSH_FRONT
                         || op_func_ff == cdq_pkg::OP_PUSH_REAR)
      |=> $stable(head_ff) && $stable(tail_ff) && !empty_ff)
      else $error("refused push moved the deque");

   // an empty deque reports zero ends and is never full
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && is_empty_ff |-> (front_out_ff == '0) && (rear_out_ff == '0) && !is_full_ff)
      else $error("empty deque reported data at its ends");

   // popped word is zero unless the step succeeded
   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !ok_ff |-> popped_ff == '0)
      else $error("popped word set on a refused step");

   // a held request stays until the result slot frees
   a_op_held: assert property (@(posedge clock) disable iff (reset)
      op_vld_ff && !go |=> op_vld_ff && $stable(op_func_ff) && $stable(op_value_ff))
      else $error("pending operation lost");

endmodule

FILE: test/testbench.sv
// self-checking testbench for the circular deque, directed and random operations
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH       = cdq_pkg::DEPTH_DEFAULT;
   localparam int HOLD_CYCLES = 60;
   localparam int FUNC_CODES  = 1 << cdq_pkg::FUNC_W;

   // one response beat as the block should present it
   typedef struct packed {
      logic                       ok;
      logic [cdq_pkg::WORD_W-1:0] popped;
      logic [cdq_pkg::WORD_W-1:0] front;
      logic [cdq_pkg::WORD_W-1:0] rear;
      logic                       empty;
      logic                       full;
   } deque_view_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata  = '0;   // push_value[31:0]
   logic [7:0]   req_tuser  = '0;   // func[2:0], zero[7:3]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;         // popped_value[31:0], front_value[63:32], rear_value[95:64]
   logic [7:0]   rsp_tuser;         // ok[0], is_empty[1], is_full[2], zero[7:3]

   // behavioral deque state
   logic [cdq_pkg::WORD_W-1:0] slot_word [DEPTH];
   int                         head_pos = 0;
   int                         tail_pos = 0;
   bit                         dq_empty = 1'b1;

   deque_view_type pending_views[$];
   int             errors     = 0;
   bit             tx_idle_on = 1'b1;
   bit             rx_idle_on = 1'b1;
   bit             hold_req   = 1'b0;

   circular_deque_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit deque_full();
      return !dq_empty && ((tail_pos + 1) % DEPTH == head_pos);
   endfunction

   // advance the behavioral deque by one operation and queue the view it should produce
   function automatic void apply_deque_op(logic [cdq_pkg::FUNC_W-1:0] func,
                                          logic [cdq_pkg::WORD_W-1:0] word);
      deque_view_type v;
      v = '0;
      case (func)
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
            if (dq_empty) begin
               // an empty deque always restarts at slot zero
               head_pos = 0;
               tail_pos = 0;
               slot_word[0] = word;
               dq_empty = 1'b0;
               v.ok = 1'b1;
            end else if (!deque_full()) begin
               if (func == cdq_pkg::OP_PUSH_FRONT) begin
                  head_pos = (head_pos + DEPTH - 1) % DEPTH;
                  slot_word[head_pos] = word;
               end else begin
                  tail_pos = (tail_pos + 1) % DEPTH;
                  slot_word[tail_pos] = word;
               end
               v.ok = 1'b1;
            end
         end
         cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
            if (!dq_empty) begin
               v.ok = 1'b1;
               v.popped = (func == cdq_pkg::OP_POP_FRONT) ? slot_word[head_pos]
                                                          : slot_word[tail_pos];
               // last word out: pointers stay where they are
               if (head_pos == tail_pos)
                  dq_empty = 1'b1;
               else if (func == cdq_pkg::OP_POP_FRONT)
                  head_pos = (head_pos + 1) % DEPTH;
               else
                  tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
            end
         end
         default: ;
      endcase
      v.empty = dq_empty;
      v.full  = deque_full();
      v.front = dq_empty ? '0 : slot_word[head_pos];
      v.rear  = dq_empty ? '0 : slot_word[tail_pos];
      pending_views.push_back(v);
   endfunction

   function automatic logic [cdq_pkg::WORD_W-1:0] rand_word();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(input logic [cdq_pkg::FUNC_W-1:0] func,
                          input logic [cdq_pkg::WORD_W-1:0] word);
      while (tx_idle_on && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= {{(8 - cdq_pkg::FUNC_W){1'b0}}, func};
      do @(posedge clock); while (!req_tready);
      apply_deque_op(func, word);
   endtask

   // stop offering beats and wait for every outstanding response
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_views.size() != 0);
   endtask

   task automatic send_random_op(input int push_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
         send_op($urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT,
                 rand_word());
      else if (pick < 94)
         send_op($urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT,
                 rand_word());
      else
         send_op(cdq_pkg::FUNC_W'($urandom_range(cdq_pkg::OP_PEEK, FUNC_CODES - 1)),
                 rand_word());
   endtask

   task automatic test_empty_ops();
      send_op(cdq_pkg::OP_PEEK, 32'hffff_ffff);
      send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
      send_op(cdq_pkg::OP_POP_REAR, 32'h0);
      // reserved codes behave like a peek
      for (int c = cdq_pkg::OP_PEEK + 1; c < FUNC_CODES; c++)
         send_op(cdq_pkg::FUNC_W'(c), rand_word());
      wait_drain();
   endtask

   task automatic test_single_word();
      send_op(cdq_pkg::OP_PUSH_REAR, 32'h7fff_ffff);
      send_op(cdq_pkg::OP_PEEK, 32'h0);
      send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
      send_op(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      send_op(cdq_pkg::OP_PUSH_REAR, 32'h0000_0000);
      send_op(cdq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
      send_op(cdq_pkg::OP_POP_REAR, 32'h0);
      send_op(cdq_pkg::OP_POP_REAR, 32'h0);
      send_op(cdq_pkg::OP_POP_REAR, 32'h0);
      send_op(cdq_pkg::OP_POP_REAR, 32'h0);
      // empty again with the pointers away from slot zero, then refill
      send_op(cdq_pkg::OP_PUSH_REAR, 32'h1234_5678);
      send_op(cdq_pkg::OP_PUSH_REAR, 32'h9abc_def0);
      send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
      send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
      send_op(cdq_pkg::OP_PUSH_FRONT, 32'h5555_aaaa);
      send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
      wait_drain();
   endtask

   task automatic test_fill_and_drain();
      for (int round = 0; round < 4; round++) begin
         while (!deque_full())
            send_op($urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT,
                    rand_word());
         send_op(cdq_pkg::OP_PUSH_FRONT, rand_word());
         send_op(cdq_pkg::OP_PUSH_REAR, rand_word());
         send_op(cdq_pkg::OP_PEEK, rand_word());
         while (!dq_empty)
            send_op($urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT,
                    rand_word());
         send_op(cdq_pkg::OP_POP_FRONT, rand_word());
         send_op(cdq_pkg::OP_POP_REAR, rand_word());
      end
      wait_drain();
   endtask

   task automatic test_random_mix();
      for (int seg = 0; seg < 10; seg++) begin
         // a long stretch without idling on either side
         tx_idle_on = (seg != 4 && seg != 5);
         rx_idle_on = tx_idle_on;
         for (int n = 0; n < 25; n++)
            send_random_op(seg[0] ? 30 : 70);
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      wait_drain();
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      for (int n = 0; n < 30; n++)
         send_random_op(60);
      wait_drain();
   endtask

   // response side ready: random idling, plus a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++)
               @(posedge clock);
         end
         rsp_tready <= (rx_idle_on && $urandom_range(0, 99) < 8) ? 1'b0 : 1'b1;
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      deque_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_views.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat, expected none, actual %h / %h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_views.pop_front();
            check_field("ok", 32'(want.ok), 32'(rsp_tuser[0]));
            check_field("popped_value", want.popped, rsp_tdata[31:0]);
            check_field("front_value", want.front, rsp_tdata[63:32]);
            check_field("rear_value", want.rear, rsp_tdata[95:64]);
            check_field("is_empty", 32'(want.empty), 32'(rsp_tuser[1]));
            check_field("is_full", 32'(want.full), 32'(rsp_tuser[2]));
            check_field("rsp_tuser pad", 32'h0, 32'(rsp_tuser[7:3]));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ops();
      test_single_word();
      test_fill_and_drain();
      test_random_mix();
      test_backpressure();
      wait_drain();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
